>>> rtl/aig_pkg.sv
// Package for the AES-256 IGE cipher: types, codes, S-box and round functions.
// No dependencies.
`default_nettype none
package aig_pkg;

  localparam int unsigned BlockBytes = 16;
  localparam int unsigned Rounds     = 14;
  localparam int unsigned RkDepth    = 2 * (Rounds + 1);
  localparam int unsigned RkAw       = $clog2(RkDepth);
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    FuncLoadPlain  = 2'd0,
    FuncLoadCipher = 2'd1,
    FuncBlock      = 2'd2,
    FuncNone       = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    RegKey0 = 3'd0,
    RegKey1 = 3'd1,
    RegKey2 = 3'd2,
    RegKey3 = 3'd3,
    RegMode = 3'd4
  } reg_e;

  typedef enum logic [1:0] {
    StIdle  = 2'd0,
    StRound = 2'd1,
    StDone  = 2'd2
  } core_state_e;

  typedef enum logic [1:0] {
    KxIdle = 2'd0,
    KxRun  = 2'd1
  } kx_state_e;

  // classified item passed from front to back
  typedef struct packed {
    func_e        func;
    logic [127:0] data;
    logic         last;
  } cmd_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // byte i of the state sits at bits [127-8i -: 8]
  function automatic logic [7:0] gb(input logic [127:0] s, input int i);
    return s[127-8*i -: 8];
  endfunction

  // forward round: SubBytes, ShiftRows, optional MixColumns (no key add)
  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic mix);
    logic [127:0] t;
    logic [127:0] o;
    logic [7:0] a0, a1, a2, a3;
    t = '0;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(r+4*c) -: 8] = sbox(gb(s, r + 4*((c+r)%4)));
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = gb(t, 4*c); a1 = gb(t, 4*c+1); a2 = gb(t, 4*c+2); a3 = gb(t, 4*c+3);
      o[127-32*c -: 32] = {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                           a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                           a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                           xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
    end
    return mix ? o : t;
  endfunction

  function automatic logic [7:0] m9(input logic [7:0] a);
    return xt(xt(xt(a))) ^ a;
  endfunction
  function automatic logic [7:0] m11(input logic [7:0] a);
    return xt(xt(xt(a))) ^ xt(a) ^ a;
  endfunction
  function automatic logic [7:0] m13(input logic [7:0] a);
    return xt(xt(xt(a))) ^ xt(xt(a)) ^ a;
  endfunction
  function automatic logic [7:0] m14(input logic [7:0] a);
    return xt(xt(xt(a))) ^ xt(xt(a)) ^ xt(a);
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] o;
    logic [7:0] a0, a1, a2, a3;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = gb(s, 4*c); a1 = gb(s, 4*c+1); a2 = gb(s, 4*c+2); a3 = gb(s, 4*c+3);
      o[127-32*c -: 32] = {m14(a0) ^ m11(a1) ^ m13(a2) ^ m9(a3),
                           m9(a0) ^ m14(a1) ^ m11(a2) ^ m13(a3),
                           m13(a0) ^ m9(a1) ^ m14(a2) ^ m11(a3),
                           m11(a0) ^ m13(a1) ^ m9(a2) ^ m14(a3)};
    end
    return o;
  endfunction

  // inverse ShiftRows then inverse SubBytes
  function automatic logic [127:0] inv_shsub(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(r+4*((c+r)%4)) -: 8] = inv_sbox(gb(s, r + 4*c));
      end
    end
    return t;
  endfunction

endpackage
`default_nettype wire

>>> rtl/aig_if.sv
// Valid/ready channel interfaces for the AES-256 IGE cipher.
// No dependencies.
`default_nettype none
interface aig_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [63:0] block_high;
  logic [63:0] block_low;
  logic        last_block;
  modport source (output valid, func, block_high, block_low, last_block, input ready);
  modport sink   (input valid, func, block_high, block_low, last_block, output ready);
endinterface

interface aig_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  logic        result_last;
  modport source (output valid, result_high, result_low, result_last, input ready);
  modport sink   (input valid, result_high, result_low, result_last, output ready);
endinterface

interface aig_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/aig_ram.sv
// Generic single-port-write, one-read RAM with registered read.
// No dependencies.
`default_nettype none
module aig_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 30
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> rtl/aig_front.sv
// Front end: accepts input transactions, drops unused codes, queues commands.
// Depends on aig_pkg and aig_if.
`default_nettype none
module aig_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  aig_in_if.sink            in_if,
  output aig_pkg::cmd_t     cmd_o,
  output logic              cmd_valid_o,
  input  wire logic         cmd_pop_i,
  output logic              empty_o
);
  import aig_pkg::*;
  localparam int unsigned Aw = $clog2(QueueDepth);

  cmd_t            q_q [QueueDepth];
  logic [Aw-1:0]   wp_q, rp_q;
  logic [Aw:0]     cnt_q;
  logic            push, pop, keep;

  assign in_if.ready = (cnt_q < (Aw+1)'(QueueDepth));
  assign keep  = (in_if.func inside {FuncLoadPlain, FuncLoadCipher, FuncBlock});
  assign push  = in_if.valid && in_if.ready && keep;
  assign pop   = cmd_pop_i && (cnt_q != '0);
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o = q_q[rp_q];
  assign empty_o = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (push) q_q[wp_q] <= '{func: func_e'(in_if.func),
                             data: {in_if.block_high, in_if.block_low},
                             last: in_if.last_block};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == Aw'(QueueDepth-1)) ? '0 : wp_q + 1'b1;
      if (pop)  rp_q <= (rp_q == Aw'(QueueDepth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(push) - (Aw+1)'(pop);
    end
  end
endmodule
`default_nettype wire

>>> rtl/aig_keyx.sv
// Key expansion: writes 30 64-bit round key words into the round key RAM.
// Depends on aig_pkg.
`default_nettype none
module aig_keyx (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [255:0]             key_i,
  output logic                          busy_o,
  output logic                          we_o,
  output logic [aig_pkg::RkAw-1:0]      waddr_o,
  output logic [63:0]                   wdata_o
);
  import aig_pkg::*;
  // window of last eight 32-bit words; one 64-bit word (two 32-bit words) a cycle
  kx_state_e      st_q, st_d;
  logic [255:0]   win_q, win_d;
  logic [RkAw-1:0] idx_q, idx_d;
  logic [7:0]     rc_q, rc_d;
  logic [31:0]    w0, w1, t;

  always_comb begin
    // idx counts 64-bit words; pair index k produces words 2k, 2k+1
    // even pairs with k%4==0 need RotWord/rcon, k%4==2 need SubWord
    t = win_q[31:0];
    if (idx_q[1:0] == 2'd0) t = sub_word({t[23:0], t[31:24]}) ^ {rc_q, 24'h0};
    else if (idx_q[1:0] == 2'd2) t = sub_word(t);
    w0 = win_q[255:224] ^ t;
    w1 = win_q[223:192] ^ w0;
  end

  always_comb begin
    st_d = st_q; win_d = win_q; idx_d = idx_q; rc_d = rc_q;
    we_o = 1'b0; waddr_o = idx_q; wdata_o = win_q[255:192];
    case (st_q)
      KxIdle: begin
        if (start_i) begin
          st_d = KxRun; win_d = key_i; idx_d = '0; rc_d = 8'h01;
        end
      end
      KxRun: begin
        we_o = 1'b1;
        if (idx_q < RkAw'(4)) begin
          wdata_o = win_q[255-64*idx_q[1:0] -: 64];
        end else begin
          wdata_o = {w0, w1};
          win_d = {win_q[191:0], w0, w1};
          if (idx_q[1:0] == 2'd0) rc_d = xt(rc_q);
        end
        if (idx_q == RkAw'(RkDepth-1)) st_d = KxIdle;
        else idx_d = idx_q + 1'b1;
        // a new key write restarts the expansion from the top
        if (start_i) begin
          st_d = KxRun; win_d = key_i; idx_d = '0; rc_d = 8'h01;
        end
      end
      default: st_d = KxIdle;
    endcase
  end
  assign busy_o = (st_q != KxIdle) || start_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= KxRun; idx_q <= '0; rc_q <= 8'h01; win_q <= '0;
    end else begin
      st_q <= st_d; idx_q <= idx_d; rc_q <= rc_d; win_q <= win_d;
    end
  end
endmodule
`default_nettype wire

>>> rtl/aig_core.sv
// Back end: IGE chaining registers and iterative AES-256 round engine.
// Depends on aig_pkg and aig_if; round keys are read through ports.
`default_nettype none
module aig_core (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  decrypt_i,
  input  wire logic                  key_busy_i,
  input  aig_pkg::cmd_t              cmd_i,
  input  wire logic                  cmd_valid_i,
  output logic                       cmd_pop_o,
  output logic [aig_pkg::RkAw-1:0]   rk_addr_o,
  input  wire logic [63:0]           rk_data_i,
  output logic                       busy_o,
  aig_out_if.source                  out_if
);
  import aig_pkg::*;
  // Each round first latches the high key half, then applies the round.
  // The key RAM read is registered, so the address is driven in the cycle before its word is used.
  core_state_e  st_q, st_d;
  logic [127:0] pp_q, pp_d, pc_q, pc_d, s_q, s_d, in_q, in_d;
  logic [63:0]  kh_q, kh_d;
  logic [3:0]   r_q, r_d;
  logic         ph_q, ph_d;
  logic         dec_q, dec_d, last_q, last_d;
  logic         ov_q, ov_d;
  logic [127:0] res_q, res_d;
  logic         rl_q, rl_d;
  logic [127:0] key, fr, ir, nxt;
  logic [3:0]   ra, rnum;
  logic         ha, rdec;

  // key word to fetch for the next cycle
  always_comb begin
    ra = r_q; ha = 1'b1; rdec = dec_q;
    if (st_q != StRound) begin
      // first high half of the block about to start
      ra = '0; ha = 1'b0; rdec = decrypt_i;
    end else if (ph_q) begin
      // high half of the following round
      ha = 1'b0;
      if (r_q != 4'(Rounds)) ra = r_q + 1'b1;
    end
  end

  // round number in key RAM order (decrypt counts down)
  assign rnum = rdec ? 4'(Rounds) - ra : ra;
  assign rk_addr_o = RkAw'({rnum, ha});
  assign key = {kh_q, rk_data_i};

  always_comb begin
    fr = enc_round(s_q, r_q != 4'(Rounds)) ^ key;
    ir = inv_shsub(s_q) ^ key;
    if (r_q != 4'(Rounds)) ir = inv_mix(ir);
    if (r_q == 4'd0) nxt = s_q ^ key;
    else nxt = dec_q ? ir : fr;
  end

  always_comb begin
    st_d = st_q; pp_d = pp_q; pc_d = pc_q; s_d = s_q; in_d = in_q; kh_d = kh_q;
    r_d = r_q; ph_d = ph_q; dec_d = dec_q; last_d = last_q;
    ov_d = ov_q; res_d = res_q; rl_d = rl_q;
    cmd_pop_o = 1'b0;
    if (out_if.ready) ov_d = 1'b0;
    case (st_q)
      StIdle: begin
        if (cmd_valid_i && !key_busy_i) begin
          case (cmd_i.func)
            FuncLoadPlain:  begin pp_d = cmd_i.data; cmd_pop_o = 1'b1; end
            FuncLoadCipher: begin pc_d = cmd_i.data; cmd_pop_o = 1'b1; end
            FuncBlock: begin
              cmd_pop_o = 1'b1;
              dec_d = decrypt_i; last_d = cmd_i.last; in_d = cmd_i.data;
              s_d = cmd_i.data ^ (decrypt_i ? pp_q : pc_q);
              r_d = '0; ph_d = 1'b0; st_d = StRound;
            end
            default: cmd_pop_o = 1'b1;
          endcase
        end
      end
      StRound: begin
        if (!ph_q) begin
          kh_d = rk_data_i; ph_d = 1'b1;
        end else begin
          s_d = nxt; ph_d = 1'b0;
          if (r_q == 4'(Rounds)) st_d = StDone;
          else r_d = r_q + 1'b1;
        end
      end
      StDone: begin
        // hold until the output register is free
        if (!ov_q || out_if.ready) begin
          ov_d = 1'b1; rl_d = last_q;
          if (dec_q) begin
            res_d = s_q ^ pc_q; pp_d = s_q ^ pc_q; pc_d = in_q;
          end else begin
            res_d = s_q ^ pp_q; pc_d = s_q ^ pp_q; pp_d = in_q;
          end
          st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  assign busy_o = (st_q != StIdle) || ov_q;
  assign out_if.valid = ov_q;
  assign out_if.result_high = res_q[127:64];
  assign out_if.result_low  = res_q[63:0];
  assign out_if.result_last = rl_q;

  always_ff @(posedge clk_i) begin
    s_q <= s_d; in_q <= in_d; kh_q <= kh_d; res_q <= res_d; rl_q <= rl_d;
    dec_q <= dec_d; last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; pp_q <= '0; pc_q <= '0; r_q <= '0; ph_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; pp_q <= pp_d; pc_q <= pc_d; r_q <= r_d; ph_q <= ph_d; ov_q <= ov_d;
    end
  end
endmodule
`default_nettype wire

>>> rtl/aes256_ige_cipher.sv
// AES-256 IGE cipher top level: config registers, front queue, key expansion, core.
// Each block passes through the queue, an issue step in the idle state, 15 rounds that each
// fetch the two 64-bit key halves, and a finish step; only one block is in the rounds at a time,
// limited by the single round unit and the single read port of the round key RAM.
// Load transactions are taken in the idle state without rounds. Reset clears chaining values
// and key; a key expansion runs after reset and after each key write, during which blocks wait.
`default_nettype none
module aes256_ige_cipher (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  aig_in_if.sink    in_if,
  aig_out_if.source out_if,
  aig_cfg_if.sink   cfg_if
);
  import aig_pkg::*;

  logic [255:0] key_q, key_d;
  logic         dec_q, dec_d;
  logic         kx_start_q;
  logic         cfg_wr;

  cmd_t              cmd;
  logic              cmd_valid, cmd_pop, q_empty;
  logic              kx_busy, kx_we, core_busy;
  logic [RkAw-1:0]   kx_addr, rk_addr;
  logic [63:0]       kx_data, rk_data;

  // config writes always accepted; a key write retriggers the expansion
  assign cfg_if.ready = 1'b1;
  assign cfg_wr = cfg_if.valid && cfg_if.ready;

  always_comb begin
    key_d = key_q;
    dec_d = dec_q;
    if (cfg_wr) begin
      case (cfg_if.index)
        RegKey0: key_d[255:192] = cfg_if.data;
        RegKey1: key_d[191:128] = cfg_if.data;
        RegKey2: key_d[127:64]  = cfg_if.data;
        RegKey3: key_d[63:0]    = cfg_if.data;
        RegMode: dec_d = cfg_if.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0; dec_q <= 1'b0; kx_start_q <= 1'b0;
    end else begin
      key_q <= key_d; dec_q <= dec_d;
      kx_start_q <= cfg_wr && (cfg_if.index inside {RegKey0, RegKey1, RegKey2, RegKey3});
    end
  end

  aig_front u_front (
    .clk_i, .rst_ni, .in_if,
    .cmd_o(cmd), .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop), .empty_o(q_empty)
  );

  aig_keyx u_keyx (
    .clk_i, .rst_ni, .start_i(kx_start_q), .key_i(key_q),
    .busy_o(kx_busy), .we_o(kx_we), .waddr_o(kx_addr), .wdata_o(kx_data)
  );

  // writes come from expansion only, reads from the core only
  aig_ram #(.Width(64), .Depth(RkDepth)) u_rk (
    .clk_i, .we_i(kx_we), .waddr_i(kx_addr), .wdata_i(kx_data),
    .raddr_i(rk_addr), .rdata_o(rk_data)
  );

  aig_core u_core (
    .clk_i, .rst_ni, .decrypt_i(dec_q), .key_busy_i(kx_busy),
    .cmd_i(cmd), .cmd_valid_i(cmd_valid), .cmd_pop_o(cmd_pop),
    .rk_addr_o(rk_addr), .rk_data_i(rk_data), .busy_o(core_busy), .out_if
  );

  // output valid and result_high must hold while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.result_high))
    else $error("result changed while stalled");
  // no command taken while round keys are being rebuilt
  a_no_pop_kx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kx_busy |-> !cmd_pop)
    else $error("command issued during key expansion");
  // an empty queue offers nothing, and the busy core pops nothing from it
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_empty |-> !cmd_valid && !(cmd_pop && core_busy))
    else $error("queue empty but command valid");
endmodule
`default_nettype wire
